### rtl/clm_pkg.sv
// Shared types and constants of the circular list manager.
`default_nettype none

package clm_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int VALUE_W        = 32;

    // Request kinds as they arrive on the input port
    localparam logic [2:0] KIND_INS_HEAD  = 3'd0;
    localparam logic [2:0] KIND_INS_TAIL  = 3'd1;
    localparam logic [2:0] KIND_INS_AFTER = 3'd2;
    localparam logic [2:0] KIND_DELETE    = 3'd3;
    localparam logic [2:0] KIND_SEARCH    = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [2:0] {
        OP_INS_HEAD,
        OP_INS_TAIL,
        OP_INS_AFTER,
        OP_DELETE,
        OP_SEARCH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  target;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/circular_list_manager.sv
// A rejected or ignored item gives its result straight from idle; an insert at head or tail
// takes a slot from the free stack or a never-used one and links it in; search and delete
// walk one node a cycle, up to LIST_DEPTH nodes, and an insert-after that finds its target
// and a free slot then takes and links a slot the same way. The back end runs one item at a
// time and takes the next only once the previous result has been handed over.
// Reset: rst_n clears the list to empty with every slot free; the node store is not cleared.
`default_nettype none

module circular_list_manager #(
    parameter int LIST_DEPTH = clm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [2:0]                            kind,
    input  wire logic signed [clm_pkg::VALUE_W-1:0]    value,
    input  wire logic signed [clm_pkg::VALUE_W-1:0]    target,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [1:0]                                 status,
    output logic                                       found
);

    logic            push_valid;
    logic            push_ready;
    clm_pkg::cmd_t   push_cmd;
    logic            pop_valid;
    logic            pop_ready;
    clm_pkg::cmd_t   pop_cmd;

    clm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .target     (target),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    clm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    clm_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found)
    );

endmodule

`default_nettype wire

### rtl/clm_front.sv
// Front end: takes items from the input port, decodes the kind and hands commands on.
`default_nettype none

module clm_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [2:0]                            kind,
    input  wire logic signed [clm_pkg::VALUE_W-1:0]    value,
    input  wire logic signed [clm_pkg::VALUE_W-1:0]    target,
    output logic                                       push_valid,
    input  wire logic                                  push_ready,
    output clm_pkg::cmd_t                              push_cmd
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    clm_pkg::cmd_t   hold_cmd_reg;
    clm_pkg::cmd_t   hold_cmd_next;
    clm_pkg::op_t    op_dec;
    logic            accept;

    always_comb
    begin
        case (kind)
            clm_pkg::KIND_INS_HEAD:  op_dec = clm_pkg::OP_INS_HEAD;
            clm_pkg::KIND_INS_TAIL:  op_dec = clm_pkg::OP_INS_TAIL;
            clm_pkg::KIND_INS_AFTER: op_dec = clm_pkg::OP_INS_AFTER;
            clm_pkg::KIND_DELETE:    op_dec = clm_pkg::OP_DELETE;
            clm_pkg::KIND_SEARCH:    op_dec = clm_pkg::OP_SEARCH;
            default:                 op_dec = clm_pkg::OP_NOP;
        endcase
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_cmd_next   = hold_cmd_reg;
        if (accept)
        begin
            hold_valid_next      = 1'b1;
            hold_cmd_next.op     = op_dec;
            hold_cmd_next.value  = value;
            hold_cmd_next.target = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

`default_nettype wire

### rtl/clm_queue.sv
// Short command queue between the front end and the list engine.
`default_nettype none

module clm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire clm_pkg::cmd_t   push_cmd,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output clm_pkg::cmd_t        pop_cmd
);

    localparam int PTR_W = (clm_pkg::QUEUE_DEPTH > 1) ? $clog2(clm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(clm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(clm_pkg::QUEUE_DEPTH - 1);

    clm_pkg::cmd_t      entry_reg [clm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(clm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/clm_back.sv
// List engine: node store, free stack, list walk and result register.
`default_nettype none

module clm_back #(
    parameter int LIST_DEPTH = clm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire clm_pkg::cmd_t   pop_cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           status,
    output logic                 found
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int VW    = clm_pkg::VALUE_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WFIRST,
        S_WALK,
        S_ALLOC,
        S_ALLOC_RD,
        S_LINK,
        S_LINK2
    } state_t;

    // Node store and free stack
    logic [VW-1:0]      val_mem  [LIST_DEPTH];
    logic [IDX_W-1:0]   link_mem [LIST_DEPTH];
    logic [IDX_W-1:0]   fs_mem   [LIST_DEPTH];
    logic [VW-1:0]      val_q;
    logic [IDX_W-1:0]   link_q;
    logic [IDX_W-1:0]   fs_q;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   fs_raddr;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [VW-1:0]      val_wdata;
    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;
    logic               fs_we;
    logic [IDX_W-1:0]   fs_waddr;
    logic [IDX_W-1:0]   fs_wdata;
    logic [CNT_W-1:0]   sp_dec;

    state_t             state_reg,       state_next;
    clm_pkg::op_t       op_reg,          op_next;
    logic [VW-1:0]      key_reg,         key_next;
    logic [VW-1:0]      value_reg,       value_next;
    logic [CNT_W-1:0]   used_reg,        used_next;
    logic [CNT_W-1:0]   sp_reg,          sp_next;
    logic [CNT_W-1:0]   fresh_reg,       fresh_next;
    logic [CNT_W-1:0]   cnt_reg,         cnt_next;
    logic [IDX_W-1:0]   tail_reg,        tail_next;
    logic [IDX_W-1:0]   cur_reg,         cur_next;
    logic [IDX_W-1:0]   prev_reg,        prev_next;
    logic [IDX_W-1:0]   anchor_reg,      anchor_next;
    logic [IDX_W-1:0]   anchor_nx_reg,   anchor_nx_next;
    logic [IDX_W-1:0]   new_reg,         new_next;
    logic               was_empty_reg,   was_empty_next;
    logic               capt_reg,        capt_next;
    logic               out_valid_reg,   out_valid_next;
    logic [1:0]         status_reg,      status_next;
    logic               found_reg,       found_next;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign sp_dec    = sp_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        used_next      = used_reg;
        sp_next        = sp_reg;
        fresh_next     = fresh_reg;
        cnt_next       = cnt_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        anchor_next    = anchor_reg;
        anchor_nx_next = anchor_nx_reg;
        new_next       = new_reg;
        was_empty_next = was_empty_reg;
        capt_next      = capt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        found_next     = found_reg;

        pop_ready  = 1'b0;
        rd_addr    = cur_reg;
        fs_raddr   = sp_dec[IDX_W-1:0];
        val_we     = 1'b0;
        val_waddr  = new_reg;
        val_wdata  = value_reg;
        link_we    = 1'b0;
        link_waddr = new_reg;
        link_wdata = anchor_nx_reg;
        fs_we      = 1'b0;
        fs_waddr   = sp_reg[IDX_W-1:0];
        fs_wdata   = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                // hold off until the previous result has been taken
                rd_addr = tail_reg;
                if (pop_valid && !out_valid_reg)
                begin
                    pop_ready  = 1'b1;
                    op_next    = pop_cmd.op;
                    value_next = pop_cmd.value;
                    key_next   = (pop_cmd.op == clm_pkg::OP_INS_AFTER) ?
                                 pop_cmd.target : pop_cmd.value;
                    capt_next  = 1'b0;
                    case (pop_cmd.op)
                        clm_pkg::OP_INS_HEAD, clm_pkg::OP_INS_TAIL:
                        begin
                            if (used_reg == FULL_CNT)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = clm_pkg::STATUS_FULL;
                                found_next     = 1'b0;
                            end
                            else
                            begin
                                anchor_next    = tail_reg;
                                capt_next      = 1'b1;
                                was_empty_next = (used_reg == '0);
                                state_next     = S_ALLOC;
                            end
                        end
                        clm_pkg::OP_INS_AFTER, clm_pkg::OP_SEARCH:
                        begin
                            if (used_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = clm_pkg::STATUS_NOT_FOUND;
                                found_next     = 1'b0;
                            end
                            else
                            begin
                                state_next = S_WFIRST;
                            end
                        end
                        clm_pkg::OP_DELETE:
                        begin
                            if (used_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = clm_pkg::STATUS_EMPTY;
                                found_next     = 1'b0;
                            end
                            else
                            begin
                                state_next = S_WFIRST;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = clm_pkg::STATUS_OK;
                            found_next     = 1'b0;
                        end
                    endcase
                end
            end

            S_WFIRST:
            begin
                // link of the tail names the head
                cur_next   = link_q;
                prev_next  = tail_reg;
                rd_addr    = link_q;
                cnt_next   = '0;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (val_q == key_reg)
                begin
                    case (op_reg)
                        clm_pkg::OP_INS_AFTER:
                        begin
                            if (used_reg == FULL_CNT)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = clm_pkg::STATUS_FULL;
                                found_next     = 1'b1;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                anchor_next    = cur_reg;
                                anchor_nx_next = link_q;
                                was_empty_next = 1'b0;
                                state_next     = S_ALLOC;
                            end
                        end
                        clm_pkg::OP_DELETE:
                        begin
                            if (used_reg == CNT_W'(1))
                            begin
                                tail_next = '0;
                            end
                            else
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg;
                                link_wdata = link_q;
                                if (cur_reg == tail_reg)
                                begin
                                    tail_next = prev_reg;
                                end
                            end
                            used_next      = used_reg - CNT_W'(1);
                            fs_we          = 1'b1;
                            sp_next        = sp_reg + CNT_W'(1);
                            out_valid_next = 1'b1;
                            status_next    = clm_pkg::STATUS_OK;
                            found_next     = 1'b1;
                            state_next     = S_IDLE;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = clm_pkg::STATUS_OK;
                            found_next     = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
                else if ((cnt_reg + CNT_W'(1)) == used_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = clm_pkg::STATUS_NOT_FOUND;
                    found_next     = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // advance one node
                    prev_next = cur_reg;
                    cur_next  = link_q;
                    rd_addr   = link_q;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end

            S_ALLOC:
            begin
                if (capt_reg)
                begin
                    anchor_nx_next = link_q;
                end
                if (sp_reg != '0)
                begin
                    sp_next    = sp_dec;
                    state_next = S_ALLOC_RD;
                end
                else
                begin
                    // no recycled slot: take the next slot never used
                    new_next   = fresh_reg[IDX_W-1:0];
                    fresh_next = fresh_reg + CNT_W'(1);
                    state_next = S_LINK;
                end
            end

            S_ALLOC_RD:
            begin
                new_next   = fs_q;
                state_next = S_LINK;
            end

            S_LINK:
            begin
                val_we     = 1'b1;
                link_we    = 1'b1;
                link_wdata = was_empty_reg ? new_reg : anchor_nx_reg;
                used_next  = used_reg + CNT_W'(1);
                if (was_empty_reg || (op_reg == clm_pkg::OP_INS_TAIL) ||
                    ((op_reg == clm_pkg::OP_INS_AFTER) && (anchor_reg == tail_reg)))
                begin
                    tail_next = new_reg;
                end
                if (was_empty_reg)
                begin
                    out_valid_next = 1'b1;
                    status_next    = clm_pkg::STATUS_OK;
                    found_next     = (op_reg == clm_pkg::OP_INS_AFTER);
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_LINK2;
                end
            end

            S_LINK2:
            begin
                link_we        = 1'b1;
                link_waddr     = anchor_reg;
                link_wdata     = new_reg;
                out_valid_next = 1'b1;
                status_next    = clm_pkg::STATUS_OK;
                found_next     = (op_reg == clm_pkg::OP_INS_AFTER);
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= clm_pkg::OP_NOP;
            key_reg       <= '0;
            value_reg     <= '0;
            used_reg      <= '0;
            sp_reg        <= '0;
            fresh_reg     <= '0;
            cnt_reg       <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            anchor_reg    <= '0;
            anchor_nx_reg <= '0;
            new_reg       <= '0;
            was_empty_reg <= 1'b0;
            capt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= clm_pkg::STATUS_OK;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            value_reg     <= value_next;
            used_reg      <= used_next;
            sp_reg        <= sp_next;
            fresh_reg     <= fresh_next;
            cnt_reg       <= cnt_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            anchor_reg    <= anchor_next;
            anchor_nx_reg <= anchor_nx_next;
            new_reg       <= new_next;
            was_empty_reg <= was_empty_next;
            capt_reg      <= capt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_q <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        fs_q <= fs_mem[fs_raddr];
    end

`ifndef ASSERT_OFF
    // between items every slot is either in the list, on the free stack or never used
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (({1'b0, used_reg} + {1'b0, sp_reg}) == {1'b0, fresh_reg}))
        else $error("slot accounting broken");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL_CNT)
        else $error("list holds more nodes than the store");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cnt_reg < used_reg))
        else $error("walk ran past the list");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |->
        (status_reg == clm_pkg::STATUS_OK || status_reg == clm_pkg::STATUS_FULL))
        else $error("found flag with a miss status");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while an item is in progress");
`endif

endmodule

`default_nettype wire
